/* src/rlerd_pkg.sv */
package rlerd_pkg;

	// field and register widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DIM_W   = 16;
	localparam int unsigned CNT_W   = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// register reset values
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd320;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd200;

	// control byte decode
	localparam logic [BYTE_W-1:0] RUN_MIN  = 8'h80;
	localparam logic [BYTE_W-1:0] LEN_MASK = 8'h7F;

	// pixels carried by one result
	localparam logic [CNT_W-1:0] ONE_PIXEL  = 2'd1;
	localparam logic [CNT_W-1:0] TWO_PIXELS = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_CTRL,
		ST_VAL,
		ST_LIT,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_ctrl;
		logic load_val;
		logic emit_run;
		logic emit_lit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ctrl_is_run;
		logic run_done;
		logic lit_done;
		logic out_free;
	} sts_t;

endpackage

/* src/rlerd_ctrl.sv */
module rlerd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  rlerd_pkg::sts_t    sts,
	output rlerd_pkg::cmd_t    cmd
);

	rlerd_pkg::state_t state_q;
	rlerd_pkg::state_t state_nxt;
	logic              s_acc;

	assign s_acc = s_tvalid && s_tready;

	// state register, a register write restarts decoding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlerd_pkg::ST_CTRL;
		end else if (cfg_we) begin
			state_q <= rlerd_pkg::ST_CTRL;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rlerd_pkg::ST_CTRL: begin
				if (s_acc) begin
					state_nxt = sts.ctrl_is_run ? rlerd_pkg::ST_VAL : rlerd_pkg::ST_LIT;
				end
			end
			rlerd_pkg::ST_VAL: begin
				if (s_acc) begin
					state_nxt = rlerd_pkg::ST_RUN;
				end
			end
			rlerd_pkg::ST_LIT: begin
				if (s_acc && sts.lit_done) begin
					state_nxt = rlerd_pkg::ST_CTRL;
				end
			end
			rlerd_pkg::ST_RUN: begin
				if (sts.out_free && sts.run_done) begin
					state_nxt = rlerd_pkg::ST_CTRL;
				end
			end
			default: state_nxt = rlerd_pkg::ST_CTRL;
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd.load_ctrl = 1'b0;
		cmd.load_val  = 1'b0;
		cmd.emit_run  = 1'b0;
		cmd.emit_lit  = 1'b0;
		case (state_q)
			rlerd_pkg::ST_CTRL: begin
				s_tready      = 1'b1;
				cmd.load_ctrl = s_tvalid;
			end
			rlerd_pkg::ST_VAL: begin
				s_tready     = 1'b1;
				cmd.load_val = s_tvalid;
			end
			rlerd_pkg::ST_LIT: begin
				s_tready     = sts.out_free;
				cmd.emit_lit = s_tvalid && sts.out_free;
			end
			rlerd_pkg::ST_RUN: begin
				cmd.emit_run = sts.out_free;
			end
			default: s_tready = 1'b0;
		endcase
	end

endmodule

/* src/rlerd_dp.sv */
module rlerd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlerd_pkg::cmd_t                     cmd,
	output rlerd_pkg::sts_t                     sts,
	input  logic [rlerd_pkg::BYTE_W-1:0]        in_byte,
	input  logic                                cfg_we,
	input  logic [rlerd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rlerd_pkg::DIM_W-1:0]         cfg_data,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [23:0]                         m_tdata,
	output logic                                m_tlast,
	output logic [1:0]                          m_tuser
);

	localparam int unsigned DW = rlerd_pkg::DIM_W;
	localparam int unsigned BW = rlerd_pkg::BYTE_W;

	// one pixel counted against row and image: {end, row_left, rows_left}
	function automatic logic [2*DW:0] count_step(
		input logic [DW-1:0] row_left,
		input logic [DW-1:0] rows_left,
		input logic [DW-1:0] width,
		input logic [DW-1:0] height
	);
		logic [2*DW:0] r;
		r = {1'b0, row_left - 16'd1, rows_left};
		if (row_left == 16'd1) begin
			if (rows_left == 16'd1) begin
				r = {1'b1, width, height};
			end else begin
				r = {1'b0, width, rows_left - 16'd1};
			end
		end
		return r;
	endfunction

	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [DW-1:0] row_left_q;
	logic [DW-1:0] rows_left_q;
	logic [BW-1:0] run_left_q;
	logic [BW-1:0] lit_left_q;
	logic [BW-1:0] pix_q;
	logic          ovr_q;

	logic          out_valid_q;
	logic [BW-1:0] out_first_q;
	logic [BW-1:0] out_second_q;
	logic [rlerd_pkg::CNT_W-1:0] out_count_q;
	logic          out_run_last_q;
	logic          out_img_last_q;
	logic          out_ovr_q;

	logic [2*DW:0] step1;
	logic [2*DW:0] step2;
	logic          end1;
	logic          two;
	logic          run_end;
	logic [BW-1:0] run_after;
	logic [BW-1:0] pkt_len;
	logic          pkt_ovr;
	logic          out_free;
	logic [DW-1:0] new_width;
	logic [DW-1:0] new_height;

	// two chained pixel counts for a pixel pair
	assign step1 = count_step(row_left_q, rows_left_q, width_q, height_q);
	assign step2 = count_step(step1[2*DW-1:DW], step1[DW-1:0], width_q, height_q);
	assign end1  = step1[2*DW];

	// run result: pair unless the image ends or one pixel is left
	assign two       = !end1 && (run_left_q > 8'd1);
	assign run_end   = two ? step2[2*DW] : end1;
	assign run_after = run_left_q - (two ? 8'd2 : 8'd1);

	// packet length and row overrun test, a zero row count means 65536
	assign pkt_len = (in_byte & rlerd_pkg::LEN_MASK) + 8'd1;
	assign pkt_ovr = (row_left_q != '0) && ({{(DW-BW){1'b0}}, pkt_len} > row_left_q);

	assign out_free = !out_valid_q || m_tready;

	assign sts.ctrl_is_run = (in_byte >= rlerd_pkg::RUN_MIN);
	assign sts.run_done    = run_end || (run_after == '0);
	assign sts.lit_done    = (lit_left_q == 8'd1) || end1;
	assign sts.out_free    = out_free;

	// register values after a configuration write
	always_comb begin
		new_width  = width_q;
		new_height = height_q;
		case (cfg_index)
			rlerd_pkg::REG_IMAGE_WIDTH:  new_width  = cfg_data;
			rlerd_pkg::REG_IMAGE_HEIGHT: new_height = cfg_data;
			default: new_width = width_q;
		endcase
	end

	// configuration, packet and image counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= rlerd_pkg::WIDTH_RESET;
			height_q    <= rlerd_pkg::HEIGHT_RESET;
			row_left_q  <= rlerd_pkg::WIDTH_RESET;
			rows_left_q <= rlerd_pkg::HEIGHT_RESET;
			run_left_q  <= '0;
			lit_left_q  <= '0;
			ovr_q       <= 1'b0;
		end else if (cfg_we) begin
			width_q     <= new_width;
			height_q    <= new_height;
			row_left_q  <= new_width;
			rows_left_q <= new_height;
			run_left_q  <= '0;
			lit_left_q  <= '0;
			ovr_q       <= 1'b0;
		end else begin
			if (cmd.load_ctrl) begin
				ovr_q <= pkt_ovr;
				if (sts.ctrl_is_run) begin
					run_left_q <= pkt_len;
				end else begin
					lit_left_q <= pkt_len;
				end
			end
			if (cmd.emit_run) begin
				row_left_q  <= two ? step2[2*DW-1:DW] : step1[2*DW-1:DW];
				rows_left_q <= two ? step2[DW-1:0] : step1[DW-1:0];
				run_left_q  <= sts.run_done ? '0 : run_after;
				if (run_end) begin
					ovr_q <= 1'b0;
				end
			end
			if (cmd.emit_lit) begin
				row_left_q  <= step1[2*DW-1:DW];
				rows_left_q <= step1[DW-1:0];
				lit_left_q  <= sts.lit_done ? '0 : lit_left_q - 8'd1;
				if (end1) begin
					ovr_q <= 1'b0;
				end
			end
		end
	end

	// run value
	always_ff @(posedge clk) begin
		if (cmd.load_val) begin
			pix_q <= in_byte;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_run || cmd.emit_lit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_run) begin
			out_first_q    <= pix_q;
			out_second_q   <= two ? pix_q : '0;
			out_count_q    <= two ? rlerd_pkg::TWO_PIXELS : rlerd_pkg::ONE_PIXEL;
			out_run_last_q <= sts.run_done;
			out_img_last_q <= run_end;
			out_ovr_q      <= ovr_q;
		end else if (cmd.emit_lit) begin
			out_first_q    <= in_byte;
			out_second_q   <= '0;
			out_count_q    <= rlerd_pkg::ONE_PIXEL;
			out_run_last_q <= 1'b1;
			out_img_last_q <= end1;
			out_ovr_q      <= ovr_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_count_q, out_second_q, out_first_q};
	assign m_tlast  = out_img_last_q;
	assign m_tuser  = {out_ovr_q, out_run_last_q};

endmodule

/* src/rle_image_row_decoder_top.sv */
// output: a result is registered and shows in the cycle after the byte or step that makes it
// control byte: no result; literal byte: one result
// run value: taken, then pixel-pair results (a single pixel where one is left or the image ends), input stalled
// throughput is set by the one-pair-per-cycle counter step in the datapath, while the output is not stalled
// reset: asynchronous active low; width 320, height 200, decoder waits for a control byte
module rle_image_row_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // in_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // pixel_first, pixel_second, pixel_count
	output logic                              m_tlast,   // image_last
	output logic [1:0]                        m_tuser,   // run_last, row_overrun
	input  logic                              cfg_we,
	input  logic [rlerd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlerd_pkg::DIM_W-1:0]       cfg_data
);

	rlerd_pkg::cmd_t cmd;
	rlerd_pkg::sts_t sts;

	// sequencer
	rlerd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counters and output register
	rlerd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	// input is held off while a run emits its pixels
	a_run_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_run |-> !s_tready)
		else $error("input accepted during run emission");

	// a result is written only into a free output register
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_run || cmd.emit_lit) |-> (!m_tvalid || m_tready))
		else $error("output transaction overwritten");

	// the image's final pixel closes the transactions of its byte
	a_image_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("image end without run_last");

	// one or two pixels in every result
	a_pixel_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:16] == rlerd_pkg::ONE_PIXEL ||
			m_tdata[17:16] == rlerd_pkg::TWO_PIXELS))
		else $error("bad pixel count");
`endif

endmodule
